FILE: hw/rtl/tdc_pkg.sv
// Shared types, constants and helper functions of the touch dimmer controller.
`default_nettype none
package tdc_pkg;

	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned HOLD_W = 16;
	localparam int unsigned RAMP_W = 8;
	localparam int unsigned CODE_W = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP = 2'd3;

	localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL = 8'd102;
	localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL = 8'd3;
	localparam logic [HOLD_W-1:0] RST_LONG_PRESS = 16'd1000;
	localparam logic [RAMP_W-1:0] RST_RAMP = 8'd25;

	localparam logic [CODE_W-1:0] CODE_OFF = 3'd0;
	localparam logic [CODE_W-1:0] CODE_WAIT_RELEASE = 3'd1;
	localparam logic [CODE_W-1:0] CODE_ON = 3'd2;
	localparam logic [CODE_W-1:0] CODE_TIMING = 3'd3;
	localparam logic [CODE_W-1:0] CODE_TURN_OFF = 3'd4;
	localparam logic [CODE_W-1:0] CODE_DIMMING = 3'd5;

	typedef enum logic [5:0] {
		M_OFF          = 6'b000001,
		M_WAIT_RELEASE = 6'b000010,
		M_ON           = 6'b000100,
		M_TIMING       = 6'b001000,
		M_TURN_OFF     = 6'b010000,
		M_DIMMING      = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] max_level;
		logic [LEVEL_W-1:0] min_level;
		logic [HOLD_W-1:0]  long_press_ms;
		logic [RAMP_W-1:0]  ramp_ms;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic [LEVEL_W-1:0] bright_level;
		logic               dim_up;
		logic [HOLD_W-1:0]  hold_timer;
		logic               hold_timing;
		logic [RAMP_W-1:0]  ramp_timer;
		logic [LEVEL_W-1:0] duty;
	} state_t;

	function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
		logic [CODE_W-1:0] c;
		case (m)
			M_OFF:          c = CODE_OFF;
			M_WAIT_RELEASE: c = CODE_WAIT_RELEASE;
			M_ON:           c = CODE_ON;
			M_TIMING:       c = CODE_TIMING;
			M_TURN_OFF:     c = CODE_TURN_OFF;
			M_DIMMING:      c = CODE_DIMMING;
			default:        c = CODE_OFF;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tdc_cfg.sv
// Configuration register file of the touch dimmer controller.
`default_nettype none
module tdc_cfg
	import tdc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_level <= RST_MAX_LEVEL;
			cfg_q.min_level <= RST_MIN_LEVEL;
			cfg_q.long_press_ms <= RST_LONG_PRESS;
			cfg_q.ramp_ms <= RST_RAMP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_LEVEL:  cfg_q.max_level <= cfg_data[LEVEL_W-1:0];
				REG_MIN_LEVEL:  cfg_q.min_level <= cfg_data[LEVEL_W-1:0];
				REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data[HOLD_W-1:0];
				REG_RAMP:       cfg_q.ramp_ms <= cfg_data[RAMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: hw/rtl/tdc_step.sv
// Next-state logic of one control pass: timer tick, then one mode step.
`default_nettype none
module tdc_step
	import tdc_pkg::*;
(
	input  wire cfg_t   cfg,
	input  wire state_t cur,
	input  wire logic   pressed,
	input  wire logic   ms_tick,
	output state_t      nxt
);

	logic [HOLD_W-1:0]  hold_t;
	logic [RAMP_W-1:0]  ramp_t;
	logic [LEVEL_W:0]   level_inc;
	logic [LEVEL_W-1:0] level_new;

	always_comb begin
		hold_t = cur.hold_timer;
		ramp_t = cur.ramp_timer;
		if (ms_tick) begin
			if (cur.hold_timing) begin
				hold_t = cur.hold_timer + 1'b1;
			end
			ramp_t = cur.ramp_timer + 1'b1;
		end
	end

	always_comb begin
		level_inc = {1'b0, cur.bright_level} + 1'b1;
		if (cur.dim_up) begin
			if (level_inc >= {1'b0, cfg.max_level}) begin
				level_new = cfg.max_level;
			end else begin
				level_new = level_inc[LEVEL_W-1:0];
			end
		end else if (cur.bright_level > cfg.min_level) begin
			level_new = cur.bright_level - 1'b1;
		end else begin
			level_new = cur.bright_level;
		end
	end

	always_comb begin
		nxt = cur;
		nxt.hold_timer = hold_t;
		nxt.ramp_timer = ramp_t;
		case (cur.mode)
			M_OFF: begin
				if (pressed) begin
					nxt.duty = cur.bright_level;
					nxt.mode = M_WAIT_RELEASE;
				end
			end
			M_WAIT_RELEASE: begin
				if (!pressed) begin
					nxt.mode = M_ON;
				end
			end
			M_ON: begin
				if (pressed) begin
					nxt.mode = M_TIMING;
					nxt.hold_timer = '0;
					nxt.hold_timing = 1'b1;
				end
			end
			M_TIMING: begin
				if (!pressed) begin
					nxt.hold_timer = '0;
					nxt.mode = M_TURN_OFF;
				end
				// A release clears the timer, and dimming needs the button still pressed, so a release never starts dimming.
				if (pressed && hold_t > cfg.long_press_ms) begin
					nxt.hold_timing = 1'b0;
					nxt.mode = M_DIMMING;
					nxt.hold_timer = '0;
					nxt.ramp_timer = '0;
				end else begin
					nxt.hold_timing = 1'b1;
				end
			end
			M_TURN_OFF: begin
				nxt.duty = '0;
				nxt.mode = M_OFF;
			end
			M_DIMMING: begin
				if (pressed) begin
					if (ramp_t > cfg.ramp_ms) begin
						nxt.ramp_timer = '0;
						nxt.bright_level = level_new;
						nxt.duty = level_new;
					end
				end else begin
					nxt.dim_up = ~cur.dim_up;
					nxt.mode = M_ON;
				end
			end
			default: begin
				nxt.mode = M_OFF;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/touch_dimmer_controller.sv
// Top level of the single-button touch dimmer controller.
//
// Channel  Direction  Payload
// s_axis   in         tdata[0] pressed, tdata[1] ms_tick
// m_axis   out        tdata[7:0] duty, tdata[10:8] mode, tdata[18:11] level
// cfg      in         cfg_index 0 max_level, 1 min_level, 2 long_press_ms, 3 ramp_ms
//
// An item is taken into an input register, stepped by the mode logic and
// written to the result register, so one item passes per cycle unless the output stalls.
// The result is valid once its item has passed the input register and the result register.
// Reset puts the lamp off at level 102 with the register reset values loaded.
// A stalled output holds both registers and lowers s_tready only when both are full.
`default_nettype none
module touch_dimmer_controller
	import tdc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // pressed, ms_tick, zero fill
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // duty, mode, level, zero fill
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg;
	state_t state_q;
	state_t state_nxt;

	logic                  valid_s1;
	logic                  pressed_s1;
	logic                  tick_s1;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  advance;
	logic                  step_en;

	tdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tdc_step u_step (
		.cfg     (cfg),
		.cur     (state_q),
		.pressed (pressed_s1),
		.ms_tick (tick_s1),
		.nxt     (state_nxt)
	);

	assign advance = !out_valid_q || m_tready;
	assign step_en = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pressed_s1 <= s_tdata[0];
			tick_s1 <= s_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= M_OFF;
			state_q.bright_level <= RST_MAX_LEVEL;
			state_q.dim_up <= 1'b0;
			state_q.hold_timer <= '0;
			state_q.hold_timing <= 1'b0;
			state_q.ramp_timer <= '0;
			state_q.duty <= '0;
		end else if (step_en) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_data_q <= {{(OUT_DATA_W - 2*LEVEL_W - CODE_W){1'b0}},
				state_nxt.bright_level, mode_code(state_nxt.mode), state_nxt.duty};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule
`default_nettype wire
